[hdl/rfpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfpd_pkg - shared types and constants of the RF remote pulse decoder
// Command format between front and back, phase codes, register indexes.
// ----------------------------------------------------------------------------
package rfpd_pkg;

	localparam int CNT_W       = 8;
	localparam int CNT_OUT_W   = 7;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int EXP_W       = 7;
	localparam int US_W        = 16;
	localparam int KEY_W       = 14;
	localparam int KEY_FIRST   = 61;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [US_W-1:0]  GLITCH_RST   = 16'd300;
	localparam logic [US_W-1:0]  BIT_GAP_RST  = 16'd600;
	localparam logic [US_W-1:0]  SYNC_GAP_RST = 16'd1600;
	localparam logic [EXP_W-1:0] EXPECTED_RST = 7'd77;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_FIRST  = 2'd1,
		PH_SECOND = 2'd2
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GLITCH   = 2'd0,
		REG_BIT_GAP  = 2'd1,
		REG_SYNC_GAP = 2'd2,
		REG_EXPECTED = 2'd3
	} reg_idx_t;

	typedef enum logic {
		CMD_APPEND = 1'b0,
		CMD_FINISH = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic             level;
		logic [CNT_W-1:0] count;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

[hdl/rf_remote_pulse_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_remote_pulse_decoder - pulse-width decoder for an RF remote bit stream
// Classifies pin edges, collects frame bits and reports bit count and key.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | pin_level, edge_interval_us
//  out     | out_valid / out_ready| frame_bit_count, key_valid, key_code
//  cfg     | cfg_wr_en            | cfg_index, cfg_data
//
//  One edge per cycle is taken while in_ready is high. A frame-ending edge's
//  command enters the queue; the result register loads when it is popped.
//  The two-entry command queue parts classifier and frame store:
//  in_ready drops only while the queue is full behind a stalled report.
//  Reset clears phase, bit count, frame store and out_valid at once, and
//  loads the threshold and expected-length registers with their defaults.
// ----------------------------------------------------------------------------
module rf_remote_pulse_decoder #(
	parameter int FRAME_BYTES = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 pin_level,
	input  logic [rfpd_pkg::US_W-1:0]            edge_interval_us,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [rfpd_pkg::CNT_OUT_W-1:0]       frame_bit_count,
	output logic                                 key_valid,
	output logic [rfpd_pkg::KEY_W-1:0]           key_code,
	input  logic                                 cfg_wr_en,
	input  logic [rfpd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rfpd_pkg::CFG_W-1:0]           cfg_data
);

	logic [rfpd_pkg::US_W-1:0]   glitch_limit_q;
	logic [rfpd_pkg::US_W-1:0]   bit_gap_q;
	logic [rfpd_pkg::US_W-1:0]   sync_gap_q;
	logic [rfpd_pkg::EXP_W-1:0]  expected_q;
	logic                        accept;
	logic                        push;
	logic                        pop;
	rfpd_pkg::cmd_t              push_cmd;
	rfpd_pkg::cmd_t              head_cmd;
	rfpd_pkg::queue_stat_t       stat;

	assign in_ready = !stat.full;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glitch_limit_q <= rfpd_pkg::GLITCH_RST;
			bit_gap_q      <= rfpd_pkg::BIT_GAP_RST;
			sync_gap_q     <= rfpd_pkg::SYNC_GAP_RST;
			expected_q     <= rfpd_pkg::EXPECTED_RST;
		end else if (cfg_wr_en) begin
			unique case (rfpd_pkg::reg_idx_t'(cfg_index))
				rfpd_pkg::REG_GLITCH:   glitch_limit_q <= cfg_data;
				rfpd_pkg::REG_BIT_GAP:  bit_gap_q      <= cfg_data;
				rfpd_pkg::REG_SYNC_GAP: sync_gap_q     <= cfg_data;
				rfpd_pkg::REG_EXPECTED: expected_q     <= cfg_data[rfpd_pkg::EXP_W-1:0];
			endcase
		end
	end

	rfpd_front #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.pin_level        (pin_level),
		.edge_interval_us (edge_interval_us),
		.glitch_limit_us  (glitch_limit_q),
		.bit_gap_us       (bit_gap_q),
		.sync_gap_us      (sync_gap_q),
		.push             (push),
		.cmd              (push_cmd)
	);

	rfpd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.stat     (stat)
	);

	rfpd_back #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_cmd        (head_cmd),
		.stat            (stat),
		.expected_bits   (expected_q),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.frame_bit_count (frame_bit_count),
		.key_valid       (key_valid),
		.key_code        (key_code)
	);

endmodule

[hdl/rfpd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfpd_front - edge classifier
// Tracks sync and bit phases, counts bits and issues append or finish commands.
// ----------------------------------------------------------------------------
module rfpd_front #(
	parameter int FRAME_BYTES = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          pin_level,
	input  logic [rfpd_pkg::US_W-1:0]     edge_interval_us,
	input  logic [rfpd_pkg::US_W-1:0]     glitch_limit_us,
	input  logic [rfpd_pkg::US_W-1:0]     bit_gap_us,
	input  logic [rfpd_pkg::US_W-1:0]     sync_gap_us,
	output logic                          push,
	output rfpd_pkg::cmd_t                cmd
);

	localparam int NBITS = 8 * FRAME_BYTES;

	rfpd_pkg::phase_t                 phase_q, phase_d;
	logic [rfpd_pkg::CNT_W-1:0]       cnt_q, cnt_d;
	logic                             is_end;
	logic                             is_short;
	logic                             is_sync;

	assign is_end   = ((!pin_level) && (edge_interval_us < glitch_limit_us)) ||
	                  (cnt_q > rfpd_pkg::CNT_W'(NBITS));
	assign is_short = edge_interval_us < bit_gap_us;
	assign is_sync  = pin_level && (edge_interval_us > sync_gap_us);

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		if (accept) begin
			unique case (phase_q)
				rfpd_pkg::PH_FIRST: begin
					if (is_end) begin
						phase_d = rfpd_pkg::PH_IDLE;
						cnt_d   = '0;
					end else begin
						phase_d = rfpd_pkg::PH_SECOND;
						cnt_d   = cnt_q + rfpd_pkg::CNT_W'(1);
					end
				end
				rfpd_pkg::PH_SECOND: begin
					priority if (is_end) begin
						phase_d = rfpd_pkg::PH_IDLE;
						cnt_d   = '0;
					end else if (is_short) begin
						phase_d = rfpd_pkg::PH_FIRST;
					end else begin
						cnt_d   = cnt_q + rfpd_pkg::CNT_W'(1);
					end
				end
				default: begin
					if (is_sync) begin
						phase_d = rfpd_pkg::PH_FIRST;
						cnt_d   = '0;
					end else begin
						phase_d = rfpd_pkg::PH_IDLE;
					end
				end
			endcase
		end
	end

	always_comb begin
		push       = 1'b0;
		cmd.kind   = rfpd_pkg::CMD_APPEND;
		cmd.level  = pin_level;
		cmd.count  = cnt_q;
		if (accept) begin
			unique case (phase_q)
				rfpd_pkg::PH_FIRST: begin
					push = 1'b1;
					if (is_end) begin
						cmd.kind = rfpd_pkg::CMD_FINISH;
					end
				end
				rfpd_pkg::PH_SECOND: begin
					priority if (is_end) begin
						push     = 1'b1;
						cmd.kind = rfpd_pkg::CMD_FINISH;
					end else if (!is_short) begin
						push     = 1'b1;
					end
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rfpd_pkg::PH_IDLE;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

[hdl/rfpd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfpd_queue - command queue
// Short FIFO between the classifier and the frame store.
// ----------------------------------------------------------------------------
module rfpd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rfpd_pkg::cmd_t        push_cmd,
	input  logic                  pop,
	output rfpd_pkg::cmd_t        head_cmd,
	output rfpd_pkg::queue_stat_t stat
);

	localparam int PTR_W  = $clog2(rfpd_pkg::QUEUE_DEPTH);
	localparam int FILL_W = $clog2(rfpd_pkg::QUEUE_DEPTH + 1);

	rfpd_pkg::cmd_t     mem_q [rfpd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [FILL_W-1:0]  fill_q;
	logic               do_push;
	logic               do_pop;

	assign stat.full  = fill_q == FILL_W'(rfpd_pkg::QUEUE_DEPTH);
	assign stat.empty = fill_q == '0;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + FILL_W'(1);
				2'b01:   fill_q <= fill_q - FILL_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[hdl/rfpd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfpd_back - frame store and result register
// Writes bits into the frame store and builds the frame report on finish.
// ----------------------------------------------------------------------------
module rfpd_back #(
	parameter int FRAME_BYTES = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rfpd_pkg::cmd_t                   head_cmd,
	input  rfpd_pkg::queue_stat_t            stat,
	input  logic [rfpd_pkg::EXP_W-1:0]       expected_bits,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [rfpd_pkg::CNT_OUT_W-1:0]   frame_bit_count,
	output logic                             key_valid,
	output logic [rfpd_pkg::KEY_W-1:0]       key_code
);

	localparam int NBITS = 8 * FRAME_BYTES;
	localparam int IDX_W = $clog2(NBITS);

	logic [NBITS-1:0]                 store_q;
	logic                             out_valid_q;
	logic [rfpd_pkg::CNT_OUT_W-1:0]   count_q;
	logic                             key_valid_q;
	logic [rfpd_pkg::KEY_W-1:0]       key_q;
	logic                             is_finish;
	logic                             do_append;
	logic                             do_finish;
	logic                             match;
	logic [IDX_W-1:0]                 wr_idx;
	logic [rfpd_pkg::KEY_W-1:0]       key_bits;

	assign is_finish = head_cmd.kind == rfpd_pkg::CMD_FINISH;
	assign pop       = !stat.empty && (!is_finish || !out_valid_q || out_ready);
	assign do_append = pop && !is_finish &&
	                   (head_cmd.count < rfpd_pkg::CNT_W'(NBITS));
	assign do_finish = pop && is_finish;
	assign wr_idx    = head_cmd.count[IDX_W-1:0];
	assign match     = head_cmd.count == rfpd_pkg::CNT_W'(expected_bits);

	always_comb begin
		for (int j = 0; j < rfpd_pkg::KEY_W; j++) begin
			key_bits[rfpd_pkg::KEY_W-1-j] = store_q[rfpd_pkg::KEY_FIRST+j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
		end else if (do_finish) begin
			store_q <= '0;
		end else if (do_append) begin
			store_q[wr_idx] <= head_cmd.level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_finish) begin
			count_q     <= head_cmd.count[rfpd_pkg::CNT_OUT_W-1:0];
			key_valid_q <= match;
			key_q       <= match ? key_bits : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_bit_count = count_q;
	assign key_valid       = key_valid_q;
	assign key_code        = key_q;

endmodule

[hdl/rfpd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfpd_checker - port-level checks of the pulse decoder
// Watches handshakes and report fields over time; bound to the top level.
// ----------------------------------------------------------------------------
module rfpd_checker #(
	parameter int FRAME_BYTES = 10
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [rfpd_pkg::CNT_OUT_W-1:0]       frame_bit_count,
	input logic                                 key_valid,
	input logic [rfpd_pkg::KEY_W-1:0]           key_code
);

	localparam int MAX_COUNT = 8 * FRAME_BYTES + 1;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_bit_count) &&
		$stable(key_valid) && $stable(key_code))
		else $error("report changed while stalled");

	a_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !key_valid |-> key_code == '0)
		else $error("key code set without key valid");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(frame_bit_count) <= MAX_COUNT)
		else $error("bit count beyond frame store");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no pending report");

	a_report_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("report without a preceding transfer");

endmodule

bind rf_remote_pulse_decoder rfpd_checker #(
	.FRAME_BYTES(FRAME_BYTES)
) u_rfpd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.frame_bit_count (frame_bit_count),
	.key_valid       (key_valid),
	.key_code        (key_code)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the RF remote pulse decoder
// Drives pin edges through the valid/ready input channel and checks every
// frame report against an in-bench decoder: sync detection, two-phase bit
// collection, glitch and overflow frame ends, and the 14-bit key extraction.
// Threshold registers are swept between rounds, the extremes included, with
// random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

	localparam int FRAME_BYTES  = 10;
	localparam int STORE_BITS   = 8 * FRAME_BYTES;
	localparam int SETTLE       = 12;
	localparam int HOLD_CYCLES  = 400;
	localparam int TARGET_EDGES = 1800;
	localparam int MAX_ROUNDS   = 60;
	localparam int ROUND_EDGES  = 150;
	localparam int RUN_LIMIT    = 400000;

	typedef struct packed {
		logic                      level;
		logic [rfpd_pkg::US_W-1:0] dt;
	} pin_edge_t;

	typedef struct packed {
		logic [rfpd_pkg::CNT_OUT_W-1:0] count;
		logic                           valid;
		logic [rfpd_pkg::KEY_W-1:0]     key;
	} report_t;

	logic                           clk;
	logic                           arst_n           = 1'b0;
	logic                           in_valid         = 1'b0;
	logic                           in_ready;
	logic                           pin_level        = 1'b0;
	logic [rfpd_pkg::US_W-1:0]      edge_interval_us = '0;
	logic                           out_valid;
	logic                           out_ready        = 1'b0;
	logic [rfpd_pkg::CNT_OUT_W-1:0] frame_bit_count;
	logic                           key_valid;
	logic [rfpd_pkg::KEY_W-1:0]     key_code;
	logic                           cfg_wr_en        = 1'b0;
	logic [rfpd_pkg::CFG_IDX_W-1:0] cfg_index        = '0;
	logic [rfpd_pkg::CFG_W-1:0]     cfg_data         = '0;

	// decoder shadow: registers and frame state
	logic [rfpd_pkg::US_W-1:0]      glitch_lim = rfpd_pkg::GLITCH_RST;
	logic [rfpd_pkg::US_W-1:0]      gap_lim    = rfpd_pkg::BIT_GAP_RST;
	logic [rfpd_pkg::US_W-1:0]      sync_lim   = rfpd_pkg::SYNC_GAP_RST;
	logic [rfpd_pkg::EXP_W-1:0]     expect_len = rfpd_pkg::EXPECTED_RST;
	rfpd_pkg::phase_t               dec_phase  = rfpd_pkg::PH_IDLE;
	int                             bit_cnt    = 0;
	logic [0:STORE_BITS-1]          frame_bits = '0;

	pin_edge_t edge_queue[$];
	report_t   pending_reports[$];

	logic in_took        = 1'b0;
	int   tx_idle_pct    = 15;
	int   rx_idle_pct    = 15;
	bit   hold_go        = 1'b0;
	bit   hold_done      = 1'b0;
	int   hold_left      = 0;
	int   pushed         = 0;
	int   accepted_edges = 0;
	int   reports_seen   = 0;
	int   keys_seen      = 0;
	int   reg_writes     = 0;
	int   fails          = 0;

	rf_remote_pulse_decoder #(
		.FRAME_BYTES(FRAME_BYTES)
	) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.pin_level       (pin_level),
		.edge_interval_us(edge_interval_us),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.frame_bit_count (frame_bit_count),
		.key_valid       (key_valid),
		.key_code        (key_code),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void take_bit(input logic lvl);
		if (bit_cnt < STORE_BITS)
			frame_bits[bit_cnt] = lvl;
		bit_cnt++;
	endfunction

	function automatic bit decode_edge(input logic lvl,
			input logic [rfpd_pkg::US_W-1:0] dt, output report_t rep);
		rep = '0;
		if (dec_phase == rfpd_pkg::PH_FIRST || dec_phase == rfpd_pkg::PH_SECOND) begin
			if ((dt < glitch_lim && !lvl) || bit_cnt > STORE_BITS) begin
				rep.count = bit_cnt[rfpd_pkg::CNT_OUT_W-1:0];
				rep.valid = (bit_cnt == int'(expect_len));
				if (rep.valid)
					rep.key = frame_bits[rfpd_pkg::KEY_FIRST +: rfpd_pkg::KEY_W];
				frame_bits = '0;
				bit_cnt = 0;
				dec_phase = rfpd_pkg::PH_IDLE;
				return 1'b1;
			end
			if (dec_phase == rfpd_pkg::PH_FIRST) begin
				take_bit(lvl);
				dec_phase = rfpd_pkg::PH_SECOND;
			end else if (dt < gap_lim) begin
				dec_phase = rfpd_pkg::PH_FIRST;
			end else begin
				take_bit(lvl);
			end
			return 1'b0;
		end
		if (dt > sync_lim && lvl) begin
			dec_phase = rfpd_pkg::PH_FIRST;
			bit_cnt = 0;
		end else begin
			dec_phase = rfpd_pkg::PH_IDLE;
		end
		return 1'b0;
	endfunction

	// interval in [lo, hi], weighted toward both ends of the range
	function automatic int pick_dt(input int lo, input int hi);
		case ($urandom_range(0, 3))
			0: return $urandom_range(lo, (hi - lo > 3) ? lo + 3 : hi);
			1: return $urandom_range((hi - lo > 3) ? hi - 3 : lo, hi);
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	function automatic int pick_len();
		int n;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: n = int'(expect_len);
			4, 5: n = int'(expect_len) + int'($urandom_range(0, 2)) - 1;
			default: n = $urandom_range(0, STORE_BITS + 1);
		endcase
		if (n < 0)
			n = 0;
		if (n > STORE_BITS + 1)
			n = STORE_BITS + 1;
		return n;
	endfunction

	task automatic push_edge(input logic lvl, input int dt);
		edge_queue.push_back('{level: lvl, dt: dt[rfpd_pkg::US_W-1:0]});
		pushed++;
	endtask

	task automatic push_glitch();
		push_edge(1'b0, pick_dt(0, int'(glitch_lim) - 1));
	endtask

	task automatic push_noise(input int n);
		int th;
		logic lvl;
		repeat (n) begin
			lvl = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 3))
				0: th = int'(glitch_lim);
				1: th = int'(gap_lim);
				2: th = int'(sync_lim);
				default: th = -10;
			endcase
			if (th < 0) begin
				th = $urandom_range(0, 65535);
			end else begin
				th = th + int'($urandom_range(0, 2)) - 1;
				if (th < 0)
					th = 0;
				if (th > 65535)
					th = 65535;
			end
			push_edge(lvl, th);
		end
	endtask

	// sync edge, nbits bits with random short pairs, then glitch or overflow end
	task automatic push_frame(input int nbits);
		int k;
		int lo;
		logic lvl;
		bit in_second;
		push_edge(1'b1, pick_dt(int'(sync_lim) + 1, 65535));
		k = 0;
		in_second = 1'b0;
		while (k < nbits) begin
			lvl = 1'($urandom_range(0, 1));
			lo = lvl ? 0 : int'(glitch_lim);
			if (!in_second) begin
				push_edge(lvl, pick_dt(lo, 65535));
				k++;
				in_second = 1'b1;
			end else if (lo < int'(gap_lim) && $urandom_range(0, 3) == 0) begin
				push_edge(lvl, pick_dt(lo, int'(gap_lim) - 1));
				in_second = 1'b0;
			end else begin
				push_edge(lvl, pick_dt((lo > int'(gap_lim)) ? lo : int'(gap_lim), 65535));
				k++;
			end
		end
		if (nbits > STORE_BITS)
			push_edge(1'($urandom_range(0, 1)), $urandom_range(0, 65535));
		else
			push_glitch();
	endtask

	task automatic set_reg(input rfpd_pkg::reg_idx_t idx, input int data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data[rfpd_pkg::CFG_W-1:0];
		case (idx)
			rfpd_pkg::REG_GLITCH:   glitch_lim = data[rfpd_pkg::US_W-1:0];
			rfpd_pkg::REG_BIT_GAP:  gap_lim    = data[rfpd_pkg::US_W-1:0];
			rfpd_pkg::REG_SYNC_GAP: sync_lim   = data[rfpd_pkg::US_W-1:0];
			rfpd_pkg::REG_EXPECTED: expect_len = data[rfpd_pkg::EXP_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_drained();
		while (accepted_edges != pushed || pending_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic run_round(input int budget);
		int start;
		start = pushed;
		while (pushed - start < budget) begin
			case ($urandom_range(0, 9))
				8: begin
					push_noise($urandom_range(1, 6));
					push_glitch();
				end
				9: begin
					push_edge(1'b1, pick_dt(int'(sync_lim) + 1, 65535));
					push_noise($urandom_range(1, 12));
					push_glitch();
				end
				default: push_frame(pick_len());
			endcase
		end
	endtask

	// sender
	always @(negedge clk) begin : edge_driver
		pin_edge_t nxt;
		if (!in_valid || in_took) begin
			if (edge_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				nxt = edge_queue.pop_front();
				in_valid         <= 1'b1;
				pin_level        <= nxt.level;
				edge_interval_us <= nxt.dt;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off on request
	always @(negedge clk) begin
		if (hold_go && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : report_monitor
		report_t want;
		report_t got;
		if (out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$error("frame report with none pending: count %0d key_valid %0b key 0x%0h",
					frame_bit_count, key_valid, key_code);
				fails++;
			end else begin
				want = pending_reports.pop_front();
				if (frame_bit_count !== want.count) begin
					$error("frame_bit_count: expected %0d, got %0d", want.count,
						frame_bit_count);
					fails++;
				end
				if (key_valid !== want.valid) begin
					$error("key_valid: expected %0b, got %0b", want.valid, key_valid);
					fails++;
				end
				if (key_code !== want.key) begin
					$error("key_code: expected 0x%0h, got 0x%0h", want.key, key_code);
					fails++;
				end
				if (want.valid)
					keys_seen++;
			end
			reports_seen++;
		end
		if (in_valid && in_ready) begin
			accepted_edges++;
			if (decode_edge(pin_level, edge_interval_us, got))
				pending_reports.push_back(got);
		end
		in_took <= in_valid && in_ready;
	end

	initial begin
		int cycles;
		for (cycles = 0; cycles < RUN_LIMIT; cycles++)
			@(posedge clk);
		$display("simulation failed");
		$finish;
	end

	initial begin
		int round;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset thresholds: idle glitch, sync boundary, empty frame, short pair
		push_edge(1'b0, 0);
		push_edge(1'b1, 1600);
		push_edge(1'b0, 65535);
		push_edge(1'b1, 1601);
		push_edge(1'b0, 299);
		push_edge(1'b1, 65535);
		push_edge(1'b0, 300);
		push_edge(1'b1, 599);
		push_edge(1'b1, 0);
		push_edge(1'b0, 600);
		push_edge(1'b1, 65535);
		push_edge(1'b0, 0);
		push_frame(77);
		wait_drained();

		// no glitch end: frames run past the store
		set_reg(rfpd_pkg::REG_GLITCH, 0);
		set_reg(rfpd_pkg::REG_BIT_GAP, 65535);
		set_reg(rfpd_pkg::REG_SYNC_GAP, 0);
		set_reg(rfpd_pkg::REG_EXPECTED, ($urandom_range(1, 511) << rfpd_pkg::EXP_W) | 81);
		push_frame(STORE_BITS + 1);
		push_frame(STORE_BITS + 1);
		wait_drained();

		// widest glitch window, no bit gap, empty frame with zero expected
		set_reg(rfpd_pkg::REG_GLITCH, 65535);
		set_reg(rfpd_pkg::REG_BIT_GAP, 0);
		set_reg(rfpd_pkg::REG_SYNC_GAP, 1000);
		set_reg(rfpd_pkg::REG_EXPECTED, 0);
		push_frame(0);
		push_frame(5);
		push_frame(STORE_BITS);
		wait_drained();

		// unreachable sync: everything stays idle
		set_reg(rfpd_pkg::REG_SYNC_GAP, 65535);
		push_noise(20);
		push_edge(1'b1, 65535);
		push_glitch();
		wait_drained();

		round = 0;
		while (pushed < TARGET_EDGES && round < MAX_ROUNDS) begin
			case ($urandom_range(0, 9))
				0: set_reg(rfpd_pkg::REG_GLITCH, 1);
				1: set_reg(rfpd_pkg::REG_GLITCH, 65535);
				default: set_reg(rfpd_pkg::REG_GLITCH, $urandom_range(1, 800));
			endcase
			case ($urandom_range(0, 9))
				0: set_reg(rfpd_pkg::REG_BIT_GAP, 0);
				1: set_reg(rfpd_pkg::REG_BIT_GAP, 65535);
				default: set_reg(rfpd_pkg::REG_BIT_GAP, $urandom_range(0, 1500));
			endcase
			case ($urandom_range(0, 9))
				0: set_reg(rfpd_pkg::REG_SYNC_GAP, 0);
				1: set_reg(rfpd_pkg::REG_SYNC_GAP, 65534);
				default: set_reg(rfpd_pkg::REG_SYNC_GAP, $urandom_range(0, 4000));
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: set_reg(rfpd_pkg::REG_EXPECTED,
					($urandom_range(0, 511) << rfpd_pkg::EXP_W) | 77);
				6, 7, 8: set_reg(rfpd_pkg::REG_EXPECTED,
					$urandom_range(1, STORE_BITS + 1));
				default: set_reg(rfpd_pkg::REG_EXPECTED,
					$urandom_range(STORE_BITS + 2, 127));
			endcase
			tx_idle_pct = (round == 1) ? 0 : 15;
			rx_idle_pct = (round == 1) ? 0 : 15;
			if (round == 2)
				hold_go = 1'b1;
			run_round(ROUND_EDGES);
			wait_drained();
			round++;
		end

		$display("%0d pin edges in, %0d frame reports checked, %0d of them with a key",
			accepted_edges, reports_seen, keys_seen);
		$display("%0d register writes over %0d random rounds, one %0d-cycle output hold-off",
			reg_writes, round, HOLD_CYCLES);
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
